FILE: rtl/sgfw_pkg.sv
// Shared constants, types and glyph font table of the scaled glyph framebuffer writer.
package sgfw_pkg;

    // Framebuffer geometry
    localparam int FB_WIDTH  = 128;
    localparam int FB_HEIGHT = 32;
    localparam int FB_PAGES  = (FB_HEIGHT + 7) / 8;
    localparam int FB_BYTES  = FB_WIDTH * FB_PAGES;
    localparam int ADDR_W    = (FB_BYTES > 1) ? $clog2(FB_BYTES) : 1;
    localparam int PAGE_W    = (FB_PAGES > 1) ? $clog2(FB_PAGES) : 1;
    localparam int MASK_W    = FB_PAGES * 8;

    // Glyph geometry and code range
    localparam int GLYPH_COLS = 5;
    localparam int GLYPH_ROWS = 7;
    localparam logic [7:0] FIRST_CODE    = 8'd32;
    localparam logic [7:0] LAST_CODE     = 8'd127;
    localparam logic [7:0] FALLBACK_CODE = 8'd63;

    // Operation codes
    localparam logic [1:0] FN_CLEAR = 2'd0;
    localparam logic [1:0] FN_DRAW  = 2'd1;
    localparam logic [1:0] FN_READ  = 2'd2;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_LOAD,
        ST_RUN,
        ST_READ,
        ST_DONE
    } state_t;

    // Framebuffer memory port request
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } ram_req_t;

    // One byte column of a 5x7 glyph; bit 0 is the top row
    function automatic logic [7:0] glyph_column(input logic [6:0] slot, input logic [2:0] col);
        logic [39:0] row;
        logic [7:0]  bits;
        unique case (slot)
            7'd0:  row = 40'h0000000000;
            7'd1:  row = 40'h00005F0000;
            7'd2:  row = 40'h0007000700;
            7'd3:  row = 40'h147F147F14;
            7'd4:  row = 40'h242A7F2A12;
            7'd5:  row = 40'h2313086462;
            7'd6:  row = 40'h3649552250;
            7'd7:  row = 40'h0005030000;
            7'd8:  row = 40'h001C224100;
            7'd9:  row = 40'h0041221C00;
            7'd10: row = 40'h082A1C2A08;
            7'd11: row = 40'h08083E0808;
            7'd12: row = 40'h0050300000;
            7'd13: row = 40'h0808080808;
            7'd14: row = 40'h0060600000;
            7'd15: row = 40'h2010080402;
            7'd16: row = 40'h3E5149453E;
            7'd17: row = 40'h00427F4000;
            7'd18: row = 40'h4261514946;
            7'd19: row = 40'h2141454B31;
            7'd20: row = 40'h1814127F10;
            7'd21: row = 40'h2745454539;
            7'd22: row = 40'h3C4A494930;
            7'd23: row = 40'h0171090503;
            7'd24: row = 40'h3649494936;
            7'd25: row = 40'h064949291E;
            7'd26: row = 40'h0036360000;
            7'd27: row = 40'h0056360000;
            7'd28: row = 40'h0008142241;
            7'd29: row = 40'h1414141414;
            7'd30: row = 40'h4122140800;
            7'd31: row = 40'h0201510906;
            7'd32: row = 40'h324979413E;
            7'd33: row = 40'h7E1111117E;
            7'd34: row = 40'h7F49494936;
            7'd35: row = 40'h3E41414122;
            7'd36: row = 40'h7F4141221C;
            7'd37: row = 40'h7F49494941;
            7'd38: row = 40'h7F09090101;
            7'd39: row = 40'h3E41415132;
            7'd40: row = 40'h7F0808087F;
            7'd41: row = 40'h00417F4100;
            7'd42: row = 40'h2040413F01;
            7'd43: row = 40'h7F08142241;
            7'd44: row = 40'h7F40404040;
            7'd45: row = 40'h7F0204027F;
            7'd46: row = 40'h7F0408107F;
            7'd47: row = 40'h3E4141413E;
            7'd48: row = 40'h7F09090906;
            7'd49: row = 40'h3E4151215E;
            7'd50: row = 40'h7F09192946;
            7'd51: row = 40'h4649494931;
            7'd52: row = 40'h01017F0101;
            7'd53: row = 40'h3F4040403F;
            7'd54: row = 40'h1F2040201F;
            7'd55: row = 40'h7F2018207F;
            7'd56: row = 40'h6314081463;
            7'd57: row = 40'h0304780403;
            7'd58: row = 40'h6151494543;
            7'd59: row = 40'h00007F4141;
            7'd60: row = 40'h0204081020;
            7'd61: row = 40'h41417F0000;
            7'd62: row = 40'h0402010204;
            7'd63: row = 40'h4040404040;
            7'd64: row = 40'h0001020400;
            7'd65: row = 40'h2054545478;
            7'd66: row = 40'h7F48444438;
            7'd67: row = 40'h3844444420;
            7'd68: row = 40'h384444487F;
            7'd69: row = 40'h3854545418;
            7'd70: row = 40'h087E090102;
            7'd71: row = 40'h081454543C;
            7'd72: row = 40'h7F08040478;
            7'd73: row = 40'h00447D4000;
            7'd74: row = 40'h2040443D00;
            7'd75: row = 40'h007F102844;
            7'd76: row = 40'h00417F4000;
            7'd77: row = 40'h7C04180478;
            7'd78: row = 40'h7C08040478;
            7'd79: row = 40'h3844444438;
            7'd80: row = 40'h7C14141408;
            7'd81: row = 40'h081414187C;
            7'd82: row = 40'h7C08040408;
            7'd83: row = 40'h4854545420;
            7'd84: row = 40'h043F444020;
            7'd85: row = 40'h3C4040207C;
            7'd86: row = 40'h1C2040201C;
            7'd87: row = 40'h3C4030403C;
            7'd88: row = 40'h4428102844;
            7'd89: row = 40'h0C5050503C;
            7'd90: row = 40'h4464544C44;
            7'd91: row = 40'h0008364100;
            7'd92: row = 40'h00007F0000;
            7'd93: row = 40'h0041360800;
            7'd94: row = 40'h08082A1C08;
            7'd95: row = 40'h081C2A0808;
            default: row = 40'h0000000000;
        endcase
        // leftmost glyph column sits in the top byte
        unique case (col)
            3'd0:    bits = row[39:32];
            3'd1:    bits = row[31:24];
            3'd2:    bits = row[23:16];
            3'd3:    bits = row[15:8];
            3'd4:    bits = row[7:0];
            default: bits = 8'h00;
        endcase
        return bits;
    endfunction

endpackage

FILE: rtl/scaled_glyph_framebuffer_writer.sv
// Top level: sequencer that clears, draws scaled glyphs into and reads the framebuffer.
//
// Page-organised monochrome framebuffer (FB_WIDTH columns, FB_HEIGHT rows, eight vertical
// pixels per byte) with one word out for every word in. Clears and draws write a single
// framebuffer memory, one byte per cycle outside the mask loads of a draw; a draw goes
// through a read-modify-write path, with the write of one byte overlapping the read of the
// next. A draw loads the scaled mask once per glyph column, then visits each page for each
// of the scale_factor screen columns of it; it ends early once the glyph runs off the right
// edge, and scale 0 draws nothing. A clear sweeps all FB_BYTES bytes (512 at the defaults),
// and a read fetches one byte. After reset the same sweep zeroes the store, and no word is
// accepted until it ends. in_ready is high only between items; a finished result sits in
// the output register while the next word is accepted.
module scaled_glyph_framebuffer_writer (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] func,
    input  logic [7:0] pos_x,
    input  logic [5:0] pos_y,
    input  logic [7:0] char_code,
    input  logic [2:0] scale_factor,
    input  logic [8:0] read_index,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] read_data
);
    import sgfw_pkg::*;

    state_t              state_reg, state_next;
    logic [1:0]          func_reg, func_next;
    logic [7:0]          code_reg, code_next;
    logic [2:0]          scale_reg, scale_next;
    logic [5:0]          pos_y_reg, pos_y_next;
    logic [8:0]          idx_reg, idx_next;
    logic [8:0]          x_reg, x_next;
    logic [2:0]          col_reg, col_next;
    logic [2:0]          dx_reg, dx_next;
    logic [PAGE_W-1:0]   page_reg, page_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [MASK_W-1:0]   col_mask_reg, col_mask_next;
    logic                pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0]   pend_addr_reg, pend_addr_next;
    logic [7:0]          pend_mask_reg, pend_mask_next;
    logic                out_valid_reg, out_valid_next;
    logic [7:0]          read_data_reg, read_data_next;

    logic [MASK_W-1:0]   mask_out;
    logic [7:0]          ram_rdata;
    ram_req_t            ram_req;
    logic [ADDR_W-1:0]   draw_addr;
    logic [7:0]          page_mask;
    logic [8:0]          x_inc;

    sgfw_glyph_mask u_mask (
        .char_code    (code_reg),
        .col          (col_reg),
        .scale_factor (scale_reg),
        .pos_y        (pos_y_reg),
        .mask         (mask_out)
    );

    sgfw_frame_ram u_ram (
        .clk   (clk),
        .req   (ram_req),
        .rdata (ram_rdata)
    );

    // Byte address and mask byte of the current page in the current screen column
    assign draw_addr = ADDR_W'(page_reg) * ADDR_W'(FB_WIDTH) + ADDR_W'(x_reg);
    assign page_mask = col_mask_reg[{page_reg, 3'b000} +: 8];
    assign x_inc     = x_reg + 9'd1;

    // State and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            clr_addr_reg   <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        func_reg      <= func_next;
        code_reg      <= code_next;
        scale_reg     <= scale_next;
        pos_y_reg     <= pos_y_next;
        idx_reg       <= idx_next;
        x_reg         <= x_next;
        col_reg       <= col_next;
        dx_reg        <= dx_next;
        page_reg      <= page_next;
        col_mask_reg  <= col_mask_next;
        pend_addr_reg <= pend_addr_next;
        pend_mask_reg <= pend_mask_next;
        read_data_reg <= read_data_next;
    end

    // Sequencer: next state, memory requests and result
    always_comb
    begin
        state_next      = state_reg;
        func_next       = func_reg;
        code_next       = code_reg;
        scale_next      = scale_reg;
        pos_y_next      = pos_y_reg;
        idx_next        = idx_reg;
        x_next          = x_reg;
        col_next        = col_reg;
        dx_next         = dx_reg;
        page_next       = page_reg;
        clr_addr_next   = clr_addr_reg;
        col_mask_next   = col_mask_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        pend_mask_next  = pend_mask_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        read_data_next  = read_data_reg;

        // finish the byte read last cycle
        ram_req.wr_en   = pend_valid_reg;
        ram_req.wr_addr = pend_addr_reg;
        ram_req.wr_data = ram_rdata | pend_mask_reg;
        ram_req.rd_en   = 1'b0;
        ram_req.rd_addr = draw_addr;

        unique case (state_reg)
            ST_INIT, ST_CLEAR:
            begin
                // zero one byte a cycle
                ram_req.wr_en   = 1'b1;
                ram_req.wr_addr = clr_addr_reg;
                ram_req.wr_data = 8'h00;
                if (clr_addr_reg == ADDR_W'(FB_BYTES - 1))
                begin
                    clr_addr_next = '0;
                    state_next    = (state_reg == ST_INIT) ? ST_IDLE : ST_DONE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    func_next  = func;
                    code_next  = char_code;
                    scale_next = scale_factor;
                    pos_y_next = pos_y;
                    idx_next   = read_index;
                    x_next     = {1'b0, pos_x};
                    col_next   = '0;
                    dx_next    = '0;
                    page_next  = '0;
                    priority case (func)
                        FN_CLEAR: state_next = ST_CLEAR;
                        FN_DRAW:  state_next = (scale_factor == 3'd0) ? ST_DONE : ST_LOAD;
                        FN_READ:  state_next = ST_READ;
                        default:  state_next = ST_DONE;
                    endcase
                end
            end
            ST_LOAD:
            begin
                // fetch the scaled mask of this glyph column
                col_mask_next = mask_out;
                state_next    = (int'(x_reg) >= FB_WIDTH) ? ST_DONE : ST_RUN;
            end
            ST_RUN:
            begin
                // read the byte; the OR and write happen next cycle
                if (page_mask != 8'h00)
                begin
                    ram_req.rd_en   = 1'b1;
                    pend_valid_next = 1'b1;
                    pend_addr_next  = draw_addr;
                    pend_mask_next  = page_mask;
                end
                if (page_reg == PAGE_W'(FB_PAGES - 1))
                begin
                    // advance to the next screen column
                    page_next = '0;
                    x_next    = x_inc;
                    if (dx_reg == scale_reg - 3'd1)
                    begin
                        dx_next = '0;
                        if (col_reg == 3'(GLYPH_COLS - 1))
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            col_next   = col_reg + 3'd1;
                            state_next = ST_LOAD;
                        end
                    end
                    else
                    begin
                        dx_next = dx_reg + 3'd1;
                    end
                    // drop the rest once past the right edge
                    if (int'(x_inc) >= FB_WIDTH)
                    begin
                        state_next = ST_DONE;
                    end
                end
                else
                begin
                    page_next = page_reg + PAGE_W'(1);
                end
            end
            ST_READ:
            begin
                ram_req.rd_en   = 1'b1;
                ram_req.rd_addr = ADDR_W'(idx_reg);
                state_next      = ST_DONE;
            end
            ST_DONE:
            begin
                // hold until the output register is free
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    if (func_reg == FN_READ && int'(idx_reg) < FB_BYTES)
                    begin
                        read_data_next = ram_rdata;
                    end
                    else
                    begin
                        read_data_next = 8'h00;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;

endmodule

FILE: rtl/sgfw_frame_ram.sv
// Framebuffer byte memory with one write port and one registered read port.
module sgfw_frame_ram (
    input  logic               clk,
    input  sgfw_pkg::ram_req_t req,
    output logic [7:0]         rdata
);
    import sgfw_pkg::*;

    logic [7:0] mem [FB_BYTES];
    logic [7:0] rdata_reg;

    // Write one byte
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
    end

    // Read one byte, hold it until the next read
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rdata_reg <= mem[req.rd_addr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sgfw_glyph_mask.sv
// Scaled and shifted vertical pixel mask of one glyph column over the full display height.
module sgfw_glyph_mask (
    input  logic [7:0]                  char_code,
    input  logic [2:0]                  col,
    input  logic [2:0]                  scale_factor,
    input  logic [5:0]                  pos_y,
    output logic [sgfw_pkg::MASK_W-1:0] mask
);
    import sgfw_pkg::*;

    localparam int EXP_W = GLYPH_ROWS * 7;
    localparam int SH_W  = EXP_W + 64;

    logic [7:0]       code;
    logic [6:0]       slot;
    logic [7:0]       bits;
    logic [EXP_W-1:0] blk;
    logic [EXP_W-1:0] expanded;
    logic [SH_W-1:0]  shifted;

    // Map codes outside the font to the question mark
    always_comb
    begin
        if (char_code < FIRST_CODE || char_code > LAST_CODE)
        begin
            code = FALLBACK_CODE;
        end
        else
        begin
            code = char_code;
        end
        slot = 7'(code - FIRST_CODE);
        bits = glyph_column(slot, col);
    end

    // Stretch each glyph dot into a run of scale rows
    always_comb
    begin
        blk      = (EXP_W'(1) << scale_factor) - EXP_W'(1);
        expanded = '0;
        for (int r = 0; r < GLYPH_ROWS; r++)
        begin
            if (bits[r])
            begin
                expanded = expanded | (blk << (6'(r) * 6'(scale_factor)));
            end
        end
    end

    // Shift down to row pos_y and drop rows below the display
    always_comb
    begin
        shifted = SH_W'(expanded) << pos_y;
        mask    = '0;
        mask[FB_HEIGHT-1:0] = shifted[FB_HEIGHT-1:0];
    end

endmodule
